>>> design/c20sc_pkg.sv
`default_nettype none

package c20sc_pkg;

   // Default number of rounds (ChaCha20).
   localparam int ROUND_COUNT_DEF = 20;

   // Bytes in one keystream block.
   localparam logic [6:0] BLOCK_BYTES = 7'd64;

   // Configuration register indexes.
   localparam logic [3:0] CSR_KEY01   = 4'd0;
   localparam logic [3:0] CSR_KEY23   = 4'd1;
   localparam logic [3:0] CSR_KEY45   = 4'd2;
   localparam logic [3:0] CSR_KEY67   = 4'd3;
   localparam logic [3:0] CSR_NONCE01 = 4'd4;
   localparam logic [3:0] CSR_NONCE2  = 4'd5;
   localparam logic [3:0] CSR_COUNTER = 4'd6;
   localparam logic [3:0] CSR_SKIP    = 4'd7;

   typedef logic [31:0] word_type;

   // The "expand 32-byte k" constant words.
   localparam word_type SIGMA0 = 32'h61707865;
   localparam word_type SIGMA1 = 32'h3320646E;
   localparam word_type SIGMA2 = 32'h79622D32;
   localparam word_type SIGMA3 = 32'h6B206574;

   // Write port of the keystream memory, driven by the round unit.
   typedef struct packed {
      logic     en;
      logic     last;
      logic [3:0] addr;
      word_type data;
   } ks_write_type;

endpackage

`default_nettype wire

>>> design/c20sc_round_unit.sv
`default_nettype none

module c20sc_round_unit #(
   parameter int RoundCount = c20sc_pkg::ROUND_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire c20sc_pkg::word_type [7:0]       key,
   input  wire c20sc_pkg::word_type [2:0]       nonce,
   input  wire c20sc_pkg::word_type             counter,
   output c20sc_pkg::ks_write_type              ks_wr
);

   localparam int RndW = $clog2(RoundCount);
   localparam logic [RndW-1:0] RndLast = RndW'(RoundCount - 1);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_ROUND = 3'b010,
      PH_FINAL = 3'b100
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                half_ff, half_in;
   logic [RndW-1:0]     rnd_ff, rnd_in;
   logic [3:0]          idx_ff, idx_in;
   c20sc_pkg::word_type w_ff [16];
   c20sc_pkg::word_type w_in [16];
   c20sc_pkg::word_type init [16];

   function automatic c20sc_pkg::word_type rotl(c20sc_pkg::word_type v, int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Init: constants, key, ctr, nonce. Hold inputs still while busy; unchecked.
   always_comb begin
      init[0] = c20sc_pkg::SIGMA0;
      init[1] = c20sc_pkg::SIGMA1;
      init[2] = c20sc_pkg::SIGMA2;
      init[3] = c20sc_pkg::SIGMA3;
      for (int i = 0; i < 8; i++) begin
         init[4 + i] = key[i];
      end
      init[12] = counter;
      for (int i = 0; i < 3; i++) begin
         init[13 + i] = nonce[i];
      end
   end

   // Half of four quarter rounds per cycle: column rounds on even rounds,
   // diagonal rounds on odd ones.
   always_comb begin
      logic [1:0]          qq;
      logic                diag;
      logic [3:0]          ia, ib, ic, id;
      c20sc_pkg::word_type a0, b0, c0, d0, a1, b1, c1, d1, t;

      diag = rnd_ff[0];
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      for (int q = 0; q < 4; q++) begin
         qq = 2'(q);
         ia = {2'b00, qq};
         ib = {2'b01, qq + (diag ? 2'd1 : 2'd0)};
         ic = {2'b10, qq + (diag ? 2'd2 : 2'd0)};
         id = {2'b11, qq + (diag ? 2'd3 : 2'd0)};
         a0 = w_ff[ia];
         b0 = w_ff[ib];
         c0 = w_ff[ic];
         d0 = w_ff[id];
         a1 = a0 + b0;
         t  = d0 ^ a1;
         d1 = half_ff ? rotl(t, 8) : rotl(t, 16);
         c1 = c0 + d1;
         t  = b0 ^ c1;
         b1 = half_ff ? rotl(t, 7) : rotl(t, 12);
         w_in[ia] = a1;
         w_in[ib] = b1;
         w_in[ic] = c1;
         w_in[id] = d1;
      end
      if (phase_ff != PH_ROUND || start) begin
         for (int i = 0; i < 16; i++) begin
            w_in[i] = start ? init[i] : w_ff[i];
         end
      end
   end

   // Sequencer over rounds and the final write-out.
   always_comb begin
      phase_in = phase_ff;
      half_in  = half_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_ROUND;
               half_in  = 1'b0;
               rnd_in   = '0;
            end
         end
         PH_ROUND: begin
            half_in = !half_ff;
            if (half_ff) begin
               rnd_in = rnd_ff + 1'b1;
               if (rnd_ff == RndLast) begin
                  phase_in = PH_FINAL;
                  idx_in   = 4'd0;
               end
            end
         end
         PH_FINAL: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'hF) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         half_ff  <= 1'b0;
         rnd_ff   <= '0;
         idx_ff   <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         half_ff  <= half_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
   end

   // Feed-forward add, one word per cycle into the keystream memory.
   always_comb begin
      ks_wr.en   = (phase_ff == PH_FINAL);
      ks_wr.last = (phase_ff == PH_FINAL) && (idx_ff == 4'hF);
      ks_wr.addr = idx_ff;
      ks_wr.data = w_ff[idx_ff] + init[idx_ff];
   end

endmodule

`default_nettype wire

>>> design/chacha20_stream_cipher.sv
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_ready  data_in, first_byte, last_byte
// rsp_      out        rsp_valid/rsp_ready  data_out, last_out
// csr_      in         csr_write_en         csr_index, csr_wdata (64 bits)
//
// A byte whose keystream block is held is taken one per cycle while the output
// does not stall. A new block runs the rounds, writes 16 words into the keystream
// memory and reads one back; it is due once per 64 bytes, on every first byte and
// whenever no block is held. The result leaves through the keystream memory read
// register and then the output register.
// Reset clears control state and configuration; the keystream memory is not cleared.
// A stalled output holds one more beat in the read stage, then req_ready drops.

module chacha20_stream_cipher #(
   parameter int RoundCount = c20sc_pkg::ROUND_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_in,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_data_out,
   output logic             rsp_last_out,
   input  wire logic        csr_write_en,
   input  wire logic [3:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CALC  = 3'b010,
      ST_ISSUE = 3'b100
   } state_type;

   // Configuration registers.
   c20sc_pkg::word_type [7:0] key_ff;
   c20sc_pkg::word_type [2:0] nonce_ff;
   c20sc_pkg::word_type       start_ctr_ff;
   logic [5:0]                skip_ff;

   // Stream control.
   state_type           state_ff, state_in;
   c20sc_pkg::word_type ctr_ff;
   logic [6:0]          pos_ff;
   logic                ks_valid_ff;

   // Item parked while a block is computed.
   logic [7:0]          hold_data_ff;
   logic                hold_last_ff;
   logic [5:0]          hold_pos_ff;

   // Read stage and output register.
   logic                pend_ff;
   logic [7:0]          pend_data_ff;
   logic                pend_last_ff;
   logic [1:0]          pend_lane_ff;
   c20sc_pkg::word_type rd_data_ff;
   logic                out_valid_ff;
   logic [7:0]          out_data_ff;
   logic                out_last_ff;

   c20sc_pkg::word_type ks_mem [16];
   c20sc_pkg::ks_write_type ks_wr;

   logic                pend_move, can_fill, accept, need_block, rd_en;
   c20sc_pkg::word_type ctr_sel;
   logic [6:0]          pos_sel;
   logic [5:0]          rd_pos;
   logic [7:0]          ks_byte;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         nonce_ff     <= '0;
         start_ctr_ff <= '0;
         skip_ff      <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            c20sc_pkg::CSR_KEY01: begin
               key_ff[0] <= csr_wdata[31:0];
               key_ff[1] <= csr_wdata[63:32];
            end
            c20sc_pkg::CSR_KEY23: begin
               key_ff[2] <= csr_wdata[31:0];
               key_ff[3] <= csr_wdata[63:32];
            end
            c20sc_pkg::CSR_KEY45: begin
               key_ff[4] <= csr_wdata[31:0];
               key_ff[5] <= csr_wdata[63:32];
            end
            c20sc_pkg::CSR_KEY67: begin
               key_ff[6] <= csr_wdata[31:0];
               key_ff[7] <= csr_wdata[63:32];
            end
            c20sc_pkg::CSR_NONCE01: begin
               nonce_ff[0] <= csr_wdata[31:0];
               nonce_ff[1] <= csr_wdata[63:32];
            end
            c20sc_pkg::CSR_NONCE2:  nonce_ff[2]  <= csr_wdata[31:0];
            c20sc_pkg::CSR_COUNTER: start_ctr_ff <= csr_wdata[31:0];
            c20sc_pkg::CSR_SKIP:    skip_ff      <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Handshake: the read stage frees when its beat moves to the output register.
   assign pend_move = pend_ff && (!out_valid_ff || rsp_ready);
   assign can_fill  = !pend_ff || pend_move;
   assign req_ready = (state_ff == ST_IDLE) && can_fill;
   assign accept    = req_valid && req_ready;

   // Counter and position for the incoming byte; decide whether a block is due.
   always_comb begin
      ctr_sel    = ctr_ff;
      pos_sel    = pos_ff;
      need_block = 1'b0;
      if (req_first_byte) begin
         ctr_sel    = start_ctr_ff;
         pos_sel    = {1'b0, skip_ff};
         need_block = 1'b1;
      end else if (!ks_valid_ff) begin
         need_block = 1'b1;
      end else if (pos_ff == c20sc_pkg::BLOCK_BYTES) begin
         ctr_sel    = ctr_ff + 32'd1;
         pos_sel    = 7'd0;
         need_block = 1'b1;
      end
   end

   // Keystream read: straight from an accepted byte, or after a block is done.
   assign rd_en  = (accept && !need_block) || ((state_ff == ST_ISSUE) && can_fill);
   assign rd_pos = (state_ff == ST_ISSUE) ? hold_pos_ff : pos_sel[5:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && need_block) state_in = ST_CALC;
         ST_CALC:  if (ks_wr.last) state_in = ST_ISSUE;
         ST_ISSUE: if (can_fill) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ctr_ff      <= '0;
         pos_ff      <= 7'd0;
         ks_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            ctr_ff <= ctr_sel;
            pos_ff <= pos_sel + 7'd1;
            if (need_block) begin
               ks_valid_ff <= 1'b0;
            end
         end
         if (ks_wr.last) begin
            ks_valid_ff <= 1'b1;
         end
      end
   end

   // Park the byte that waits for its block.
   always_ff @(posedge clock) begin
      if (accept && need_block) begin
         hold_data_ff <= req_data_in;
         hold_last_ff <= req_last_byte;
         hold_pos_ff  <= pos_sel[5:0];
      end
   end

   // The round unit sees the selected counter at start and the stored one while
   // it runs, so a new byte waiting at the input cannot disturb the final add.
   c20sc_round_unit #(
      .RoundCount(RoundCount)
   ) u_round (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && need_block),
      .key     (key_ff),
      .nonce   (nonce_ff),
      .counter ((state_ff == ST_IDLE) ? ctr_sel : ctr_ff),
      .ks_wr   (ks_wr)
   );

   // Keystream memory: one write port from the round unit, one registered read.
   always_ff @(posedge clock) begin
      if (ks_wr.en) begin
         ks_mem[ks_wr.addr] <= ks_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= ks_mem[rd_pos[5:2]];
      end
   end

   // Read stage: the beat waiting on the memory read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (rd_en) begin
         pend_ff <= 1'b1;
      end else if (pend_move) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         pend_data_ff <= (state_ff == ST_ISSUE) ? hold_data_ff : req_data_in;
         pend_last_ff <= (state_ff == ST_ISSUE) ? hold_last_ff : req_last_byte;
         pend_lane_ff <= rd_pos[1:0];
      end
   end

   // Byte lane of the keystream word, least significant byte first.
   assign ks_byte = 8'(rd_data_ff >> {pend_lane_ff, 3'b000});

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pend_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         out_data_ff <= pend_data_ff ^ ks_byte;
         out_last_ff <= pend_last_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;
   assign rsp_last_out = out_last_ff;

endmodule

`default_nettype wire
